[rtl/xmck_pkg.sv]
`timescale 1ns / 1ps

package xmck_pkg;

  // Protocol framing
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned OFFSET_BITS = 24;
  localparam int unsigned IDX_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned TICK_W      = 21;

  localparam logic [OFFSET_BITS:0] OFF_MAX  = {1'b0, {OFFSET_BITS{1'b1}}};
  localparam logic [TICK_W-1:0]    TICK_MAX = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0]    NAK_INTERVAL_RST = TICK_W'(2000000);

  // Control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_ALL = 8'hFF;

  // Input word kinds
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // Session status
  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_CANCEL   = 3'd2,
    ST_ERROR    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // Receive phase, one-hot
  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_NUMBER   = 6'b000010,
    PH_COMPL    = 6'b000100,
    PH_DATA     = 6'b001000,
    PH_CHECK    = 6'b010000,
    PH_FINISHED = 6'b100000
  } phase_e;

  // One result word
  typedef struct packed {
    logic                   tx_valid;
    logic [7:0]             tx_byte;
    logic                   wr_valid;
    logic [OFFSET_BITS-1:0] wr_offset;
    logic [7:0]             wr_data;
    status_e                status;
    logic [OFFSET_BITS-1:0] total_bytes;
  } res_t;

endpackage

[rtl/xmodem_checksum_receiver.sv]
`timescale 1ns / 1ps

// XMODEM receiver, 8-bit checksum, 128-byte blocks.
// Input stream (s_axis): one word per received byte, idle tick or restart;
// tuser carries the kind, tdata the byte. Output stream (m_axis): exactly one
// result word per input word, carrying the ACK/NAK to send, the image write
// (offset and data), the session status and the count of good bytes.
// Config channel: cfg_data_i sets the start-NAK tick interval; always ready.
// It must be written only while the block is idle; the block does not enforce this.
// Path: an accepted word waits in the input register; its result is then
// captured in the result register and presented on m_axis from there.
// Throughput: one word per cycle while m_axis_tready_i is high, set by the
// combinational state update between the input and result registers.
// Reset: the session returns to the header phase, block 1, count zero, status
// running; the interval returns to 2000000 ticks.
// Stall: while m_axis_tready_i is low the result word holds; the input register
// still takes one more word, then s_axis_tready_o drops until the result goes.

module xmodem_checksum_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [7:0] rx_byte
  input  logic [7:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] tx_byte, [31:8] wr_offset, [39:32] wr_data, [42:40] status,
  // [66:43] total_bytes, [71:67] zero
  output logic [71:0] m_axis_tdata_o,
  // [0] tx_valid, [1] wr_valid
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [20:0] cfg_data_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o
);
  import xmck_pkg::*;

  logic              in_vld_q;
  op_e               op_q;
  logic [7:0]        byte_q;
  logic              out_vld_q;
  res_t              res_q;
  res_t              res_d;
  logic [TICK_W-1:0] nak_int_q;
  logic              adv;
  logic              step;
  logic              s_fire;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && adv;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // Interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nak_int_q <= NAK_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      nak_int_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= op_e'(s_axis_tuser_i);
      byte_q <= s_axis_tdata_i;
    end
  end

  xmck_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .op_i           (op_q),
    .rx_byte_i      (byte_q),
    .nak_interval_i (nak_int_q),
    .res_o          (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = {res_q.wr_valid, res_q.tx_valid};
  assign m_axis_tdata_o  = {5'd0, res_q.total_bytes, res_q.status, res_q.wr_data,
                            res_q.wr_offset, res_q.tx_byte};

  // Only ACK or NAK is ever sent
  a_tx_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.tx_valid) |->
      (res_q.tx_byte == CH_ACK || res_q.tx_byte == CH_NAK))
    else $error("tx byte is neither ACK nor NAK");

  // A word never both answers and writes
  a_tx_wr_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.tx_valid && res_q.wr_valid))
    else $error("tx and image write in one word");

  // No image write once the session has ended
  a_no_wr_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.status != ST_RUN) |-> !res_q.wr_valid)
    else $error("image write after session end");

  // Good-byte count moves in whole blocks
  a_count_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.total_bytes[IDX_W-1:0] == '0))
    else $error("byte count not block aligned");

endmodule

[rtl/xmck_core.sv]
`timescale 1ns / 1ps

module xmck_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  xmck_pkg::op_e              op_i,
  input  logic [7:0]                 rx_byte_i,
  input  logic [xmck_pkg::TICK_W-1:0] nak_interval_i,
  output xmck_pkg::res_t             res_o
);
  import xmck_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [7:0]             exp_blk_q, exp_blk_d;
  logic                   started_q, started_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [7:0]             sum_q, sum_d;
  logic [OFFSET_BITS-1:0] count_q, count_d;
  logic [TICK_W-1:0]      ticks_q, ticks_d;
  status_e                status_q, status_d;

  logic [OFFSET_BITS:0]   count_ext;
  logic                   no_room;

  // Overflow test on the first data byte of a block
  assign count_ext = {1'b0, count_q} + (OFFSET_BITS + 1)'(BLOCK_BYTES);
  assign no_room   = (count_ext > OFF_MAX);

  // Next state and result for the word in the input register
  always_comb begin
    phase_d   = phase_q;
    exp_blk_d = exp_blk_q;
    started_d = started_q;
    idx_d     = idx_q;
    sum_d     = sum_q;
    count_d   = count_q;
    ticks_d   = ticks_q;
    status_d  = status_q;

    res_o           = '0;
    res_o.status    = ST_RUN;

    case (op_i)
      OP_RESTART: begin
        phase_d   = PH_HEADER;
        exp_blk_d = 8'd1;
        started_d = 1'b0;
        idx_d     = '0;
        sum_d     = '0;
        count_d   = '0;
        ticks_d   = '0;
        status_d  = ST_RUN;
      end
      OP_TICK: begin
        // start NAKs, only before the first SOH
        if (phase_q == PH_HEADER && !started_q) begin
          if (ticks_q > nak_interval_i) begin
            ticks_d        = '0;
            res_o.tx_valid = 1'b1;
            res_o.tx_byte  = CH_NAK;
          end else if (ticks_q != TICK_MAX) begin
            ticks_d = ticks_q + 1'b1;
          end
        end
      end
      OP_BYTE: begin
        case (phase_q)
          PH_HEADER: begin
            if (!started_q) ticks_d = '0;
            if (rx_byte_i == CH_EOT) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = CH_ACK;
              status_d       = ST_DONE;
              phase_d        = PH_FINISHED;
            end else if (rx_byte_i == CH_CAN) begin
              status_d = ST_CANCEL;
              phase_d  = PH_FINISHED;
            end else if (rx_byte_i == CH_SOH) begin
              started_d = 1'b1;
              phase_d   = PH_NUMBER;
            end else if (started_q) begin
              status_d = ST_ERROR;
              phase_d  = PH_FINISHED;
            end
          end
          PH_NUMBER: begin
            if (rx_byte_i != exp_blk_q) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = CH_NAK;
              phase_d        = PH_HEADER;
            end else begin
              phase_d = PH_COMPL;
            end
          end
          PH_COMPL: begin
            if ((exp_blk_q ^ rx_byte_i) != CH_ALL) begin
              res_o.tx_valid = 1'b1;
              res_o.tx_byte  = CH_NAK;
              phase_d        = PH_HEADER;
            end else begin
              idx_d   = '0;
              sum_d   = '0;
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            if (idx_q == '0 && no_room) begin
              status_d = ST_OVERFLOW;
              phase_d  = PH_FINISHED;
            end else begin
              res_o.wr_valid  = 1'b1;
              res_o.wr_offset = count_q + OFFSET_BITS'(idx_q);
              res_o.wr_data   = rx_byte_i;
              sum_d           = sum_q + rx_byte_i;
              if (idx_q == IDX_W'(BLOCK_BYTES - 1)) begin
                idx_d   = '0;
                phase_d = PH_CHECK;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
          end
          PH_CHECK: begin
            res_o.tx_valid = 1'b1;
            if (sum_q == rx_byte_i) begin
              exp_blk_d     = exp_blk_q + 8'd1;
              count_d       = count_q + OFFSET_BITS'(BLOCK_BYTES);
              res_o.tx_byte = CH_ACK;
            end else begin
              res_o.tx_byte = CH_NAK;
            end
            phase_d = PH_HEADER;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res_o.status      = status_d;
    res_o.total_bytes = count_d;
  end

  // Session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      exp_blk_q <= 8'd1;
      started_q <= 1'b0;
      idx_q     <= '0;
      sum_q     <= '0;
      count_q   <= '0;
      ticks_q   <= '0;
      status_q  <= ST_RUN;
    end else if (step_i) begin
      phase_q   <= phase_d;
      exp_blk_q <= exp_blk_d;
      started_q <= started_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      count_q   <= count_d;
      ticks_q   <= ticks_d;
      status_q  <= status_d;
    end
  end

endmodule
